// ===== sv/pli_pkg.sv =====
// Package for the positional list: command and status codes, and the control
// word that the list controller broadcasts to every storage cell.
// Depends on nothing; used by pli_cell and positional_list_insert_delete_search.
`timescale 1ns / 1ps

package pli_pkg;

	// Width of one stored entry and of the position field.
	localparam int ENTRY_W = 32;
	localparam int POS_W   = 7;

	// Command codes carried on the slave-side tuser.
	typedef enum logic [2:0] {
		CMD_CLEAR  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_DUMP   = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4,
		CMD_SEARCH = 3'd5
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// What each cell does in a cycle.
	typedef enum logic [2:0] {
		CELL_HOLD   = 3'd0,
		CELL_LOAD   = 3'd1,
		CELL_INSERT = 3'd2,
		CELL_DELETE = 3'd3,
		CELL_ROTATE = 3'd4,
		CELL_SEARCH = 3'd5
	} cell_op_t;

	// Control word shared by the whole row of cells.
	// pos is the insert or delete position, the append slot, the rotation end
	// or the number of valid entries for a search, depending on op.
	typedef struct packed {
		cell_op_t             op;
		logic [POS_W-1:0]     pos;
		logic [ENTRY_W-1:0]   value;
	} cell_ctl_t;

endpackage

// ===== sv/pli_cell.sv =====
// One storage cell of the positional list: holds a single entry and moves it
// to or from its neighbours as the broadcast control word says.
// Depends on pli_pkg.
`timescale 1ns / 1ps

module pli_cell #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  pli_pkg::cell_ctl_t         ctl,
	input  logic [pli_pkg::ENTRY_W-1:0] left,
	input  logic [pli_pkg::ENTRY_W-1:0] right,
	output logic [pli_pkg::ENTRY_W-1:0] data,
	output logic                       match
);
	import pli_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

	logic [ENTRY_W-1:0] data_q;
	logic               match_q;

	// Entry update: the cell's own place against the broadcast position decides
	// whether it loads the new value, takes a neighbour's entry or holds.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_LOAD: begin
				if (MY_POS == ctl.pos) begin
					data_q <= ctl.value;
				end
			end
			CELL_INSERT: begin
				if (MY_POS > ctl.pos) begin
					data_q <= left;
				end else if (MY_POS == ctl.pos) begin
					data_q <= ctl.value;
				end
			end
			CELL_DELETE: begin
				if (MY_POS >= ctl.pos) begin
					data_q <= right;
				end
			end
			CELL_ROTATE: begin
				if (MY_POS == ctl.pos) begin
					data_q <= ctl.value;
				end else if (MY_POS < ctl.pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	// Key compare, only counted for cells that hold a valid entry.
	always_ff @(posedge clk) begin
		if (ctl.op == CELL_SEARCH) begin
			match_q <= (data_q == ctl.value) && (MY_POS < ctl.pos);
		end
	end

	assign data  = data_q;
	assign match = match_q;

endmodule

// ===== sv/positional_list_insert_delete_search.sv =====
// Top level of the positional list: command decode, count register, result
// register and the row of storage cells. Depends on pli_pkg and pli_cell.
//
//  channel  direction  tdata fields (lowest bit up)                    tuser / tlast
//  s_       in         position[6:0], value[38:7]                      tuser: command
//  m_       out        status[1:0], index[7:2], entry_value[39:8],     tuser: empty_res
//                      count[46:40]                                    tlast: last
//
// Clear, append, insert and delete need no sequencer state; insert and delete shift
// every cell at once. Search passes through S_SRCH: the cells compare on accept, then
// the first match is registered as the result. Dump of an empty list gives one empty
// result; otherwise S_DUMP sends one entry per cycle while m_ is not stalled,
// rotating the row past cell 0, so the list is back in place when the last entry leaves.
// A new request is taken once the previous command has finished and the
// result register is free or being emptied; a stalled m_ side holds the row.
// Reset clears the count, the state and the result valid; entries need none.
`timescale 1ns / 1ps

module positional_list_insert_delete_search #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[6:0], value[38:7], zero pad
	input  logic [2:0]  s_tuser,   // command[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // status[1:0], index[7:2], entry_value[39:8], count[46:40]
	output logic        m_tuser,   // empty_res
	output logic        m_tlast
);
	import pli_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DUMP = 3'b010,
		S_SRCH = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     dump_idx_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [5:0]           out_index_q;
	logic [ENTRY_W-1:0]   out_value_q;
	logic [6:0]           out_count_q;
	logic                 out_empty_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 accept;
	logic                 late_result;
	cmd_t                 cmd;
	logic [POS_W-1:0]     pos;
	logic [ENTRY_W-1:0]   key;
	logic [POS_W-1:0]     count_ext;
	logic                 dump_last;

	cell_ctl_t            ctl;
	logic [ENTRY_W-1:0]   cell_data [CAPACITY];
	logic [CAPACITY-1:0]  cell_match;
	logic                 hit;
	logic [IDX_W-1:0]     hit_idx;

	// Request fields and handshake.
	assign cmd       = cmd_t'(s_tuser);
	assign pos       = s_tdata[POS_W-1:0];
	assign key       = s_tdata[POS_W+ENTRY_W-1:POS_W];
	assign count_ext = POS_W'(count_q);
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == S_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign dump_last = (CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q;

	// A search or a dump of a non-empty list produces its results later.
	assign late_result = (cmd == CMD_SEARCH) || ((cmd == CMD_DUMP) && (count_q != '0));

	// Row of cells; the end cells see themselves as the missing neighbour.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [ENTRY_W-1:0] left_in;
		logic [ENTRY_W-1:0] right_in;
		if (g == 0) begin : g_first
			assign left_in = cell_data[g];
		end else begin : g_inner_l
			assign left_in = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_in = cell_data[g];
		end else begin : g_inner_r
			assign right_in = cell_data[g+1];
		end
		pli_cell #(
			.IDX(g)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_in),
			.right(right_in),
			.data (cell_data[g]),
			.match(cell_match[g])
		);
	end

	// First matching cell, lowest index winning.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	// Control word for the cells.
	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.pos   = pos;
		ctl.value = key;
		if (accept) begin
			priority case (cmd)
				CMD_APPEND: begin
					if (count_q != CNT_FULL) begin
						ctl.op  = CELL_LOAD;
						ctl.pos = count_ext;
					end
				end
				CMD_INSERT: begin
					if (pos <= count_ext && count_q != CNT_FULL) begin
						ctl.op = CELL_INSERT;
					end
				end
				CMD_DELETE: begin
					if (pos < count_ext) begin
						ctl.op = CELL_DELETE;
					end
				end
				CMD_SEARCH: begin
					ctl.op  = CELL_SEARCH;
					ctl.pos = count_ext;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DUMP && out_free) begin
			ctl.op    = CELL_ROTATE;
			ctl.pos   = count_ext - POS_W'(1);
			ctl.value = cell_data[0];
		end
	end

	// Sequencer and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			dump_idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_APPEND: begin
								if (count_q != CNT_FULL) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_DUMP: begin
								dump_idx_q <= '0;
								if (count_q != '0) begin
									state_q <= S_DUMP;
								end
							end
							CMD_INSERT: begin
								if (pos <= count_ext && count_q != CNT_FULL) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_DELETE: begin
								if (pos < count_ext) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							CMD_SEARCH: begin
								state_q <= S_SRCH;
							end
							default: begin
							end
						endcase
					end
				end
				S_DUMP: begin
					if (out_free) begin
						dump_idx_q <= dump_idx_q + IDX_W'(1);
						if (dump_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SRCH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && !late_result) || (state_q != S_IDLE && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= ST_OK;
			out_index_q  <= '0;
			out_value_q  <= '0;
			out_empty_q  <= 1'b0;
			out_last_q   <= 1'b1;
			out_count_q  <= 7'(count_q);
			priority case (cmd)
				CMD_CLEAR: begin
					out_count_q <= '0;
				end
				CMD_APPEND: begin
					if (count_q == CNT_FULL) begin
						out_status_q <= ST_FULL;
					end else begin
						out_count_q <= 7'(count_q) + 7'd1;
					end
				end
				CMD_DUMP: begin
					out_empty_q <= 1'b1;
				end
				CMD_INSERT: begin
					if (pos > count_ext) begin
						out_status_q <= ST_RANGE;
					end else if (count_q == CNT_FULL) begin
						out_status_q <= ST_FULL;
					end else begin
						out_count_q <= 7'(count_q) + 7'd1;
					end
				end
				CMD_DELETE: begin
					if (pos >= count_ext) begin
						out_status_q <= ST_RANGE;
					end else begin
						out_count_q <= 7'(count_q) - 7'd1;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_DUMP && out_free) begin
			out_status_q <= ST_OK;
			out_index_q  <= 6'(dump_idx_q);
			out_value_q  <= cell_data[0];
			out_count_q  <= 7'(count_q);
			out_empty_q  <= 1'b0;
			out_last_q   <= dump_last;
		end else if (state_q == S_SRCH && out_free) begin
			out_status_q <= hit ? ST_OK : ST_MISS;
			out_index_q  <= hit ? 6'(hit_idx) : 6'd0;
			out_value_q  <= '0;
			out_count_q  <= 7'(count_q);
			out_empty_q  <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_count_q, out_value_q, out_index_q, out_status_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== sim/tb_positional_list_insert_delete_search.sv =====
// Self-checking testbench for the positional list: a queued request driver, a result
// monitor and a built-in predictor of list contents and count. Needs pli_pkg and the RTL.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_search;
	import pli_pkg::*;

	localparam int LIST_CAP     = 64;
	localparam int TOTAL_REQS   = 380;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;
	// Command codes that the block must ignore.
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]  cmd;
		logic [6:0]  pos;
		logic [31:0] value;
	} list_req_t;

	typedef struct {
		status_t     status;
		logic [5:0]  index;
		logic [31:0] value;
		logic [6:0]  count;
		logic        empty;
		logic        last;
	} list_result_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata  = '0;
	logic [2:0]  s_tuser  = '0;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [47:0] m_tdata;
	wire         m_tuser;
	wire         m_tlast;

	positional_list_insert_delete_search #(
		.CAPACITY(LIST_CAP)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Request queue and a running count used to shape the stimulus.
	list_req_t    commands_to_send[$];
	logic [31:0]  key_pool[$];
	int           gen_count   = 0;
	int           reqs_queued = 0;

	// Predicted list contents and the results still owed by the block.
	logic [31:0]  model_entries[LIST_CAP];
	int           model_count = 0;
	list_result_t list_results_due[$];

	int accepted_reqs = 0;
	int seen_results  = 0;
	int fail_cnt      = 0;
	int n_dumps = 0, n_hits = 0, n_misses = 0, n_full = 0, n_range = 0, max_len = 0;

	// Stretch of the run in which neither side idles.
	wire steady = (accepted_reqs >= 150) && (accepted_reqs < 250);

	task automatic queue_request(input logic [2:0] cmd, input int pos, input logic [31:0] val);
		list_req_t r;
		r.cmd   = cmd;
		r.pos   = pos[6:0];
		r.value = val;
		commands_to_send.push_back(r);
		reqs_queued++;
		case (cmd)
			CMD_CLEAR:  gen_count = 0;
			CMD_APPEND: if (gen_count < LIST_CAP) gen_count++;
			CMD_INSERT: if (pos <= gen_count && gen_count < LIST_CAP) gen_count++;
			CMD_DELETE: if (pos < gen_count) gen_count--;
			default: ;
		endcase
		if ((cmd == CMD_APPEND || cmd == CMD_INSERT) && key_pool.size() < 48)
			key_pool.push_back(val);
	endtask

	// Mostly random words, with the signed extremes, zero and all ones mixed in.
	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 15);
		case (sel)
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Search keys come mostly from values appended or inserted earlier, so that searches hit.
	function automatic logic [31:0] pick_key();
		if (key_pool.size() == 0 || $urandom_range(0, 3) == 0)
			return pick_value();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// Fill the list to capacity, then probe append, insert, delete, search and dump against a full list.
	task automatic fill_list();
		while (gen_count < LIST_CAP - 1)
			queue_request(CMD_APPEND, $urandom_range(0, 64), pick_value());
		queue_request(CMD_INSERT, $urandom_range(0, gen_count), pick_value());
		queue_request(CMD_APPEND, 0, pick_value());
		queue_request(CMD_INSERT, $urandom_range(0, 64), pick_value());
		queue_request(CMD_DELETE, 64, pick_value());
		queue_request(CMD_SEARCH, 0, pick_key());
		queue_request(CMD_DUMP, 0, pick_value());
		queue_request(CMD_DELETE, $urandom_range(0, LIST_CAP - 1), pick_value());
	endtask

	// One random request, mostly well formed for the current list length.
	task automatic queue_random_request();
		int sel;
		int pos;
		sel = $urandom_range(0, 99);
		if (sel < 24) begin
			queue_request(CMD_APPEND, $urandom_range(0, 64), pick_value());
		end else if (sel < 44) begin
			pos = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_count)
			                                   : $urandom_range(0, 64);
			queue_request(CMD_INSERT, pos, pick_value());
		end else if (sel < 64) begin
			if (gen_count > 0 && $urandom_range(0, 99) < 85)
				pos = $urandom_range(0, gen_count - 1);
			else
				pos = $urandom_range(gen_count, 64);
			queue_request(CMD_DELETE, pos, pick_value());
		end else if (sel < 80) begin
			queue_request(CMD_SEARCH, $urandom_range(0, 64), pick_key());
		end else if (sel < 89) begin
			queue_request(CMD_DUMP, $urandom_range(0, 64), pick_value());
		end else if (sel < 94) begin
			queue_request(CMD_CLEAR, $urandom_range(0, 64), pick_value());
		end else if (sel < 97) begin
			queue_request(CMD_SPARE6, $urandom_range(0, 64), pick_value());
		end else begin
			queue_request(CMD_SPARE7, $urandom_range(0, 64), pick_value());
		end
	endtask

	// Apply one accepted request to the predicted list and queue its results.
	task automatic apply_list_command(input list_req_t r);
		list_result_t res;
		int n;
		int i;
		int hit_at;
		n = model_count;
		hit_at = -1;
		res.status = ST_OK;
		res.index  = '0;
		res.value  = '0;
		res.empty  = 1'b0;
		res.last   = 1'b1;
		case (r.cmd)
			CMD_CLEAR: model_count = 0;
			CMD_APPEND: begin
				if (n >= LIST_CAP) begin
					res.status = ST_FULL;
				end else begin
					model_entries[n] = r.value;
					model_count = n + 1;
				end
			end
			CMD_DUMP: begin
				n_dumps++;
				if (n == 0)
					res.empty = 1'b1;
			end
			CMD_INSERT: begin
				if (r.pos > n) begin
					res.status = ST_RANGE;
				end else if (n >= LIST_CAP) begin
					res.status = ST_FULL;
				end else begin
					for (i = n; i > r.pos; i--)
						model_entries[i] = model_entries[i - 1];
					model_entries[r.pos] = r.value;
					model_count = n + 1;
				end
			end
			CMD_DELETE: begin
				if (r.pos >= n) begin
					res.status = ST_RANGE;
				end else begin
					for (i = r.pos; i + 1 < n; i++)
						model_entries[i] = model_entries[i + 1];
					model_count = n - 1;
				end
			end
			CMD_SEARCH: begin
				for (i = n - 1; i >= 0; i--)
					if (model_entries[i] == r.value)
						hit_at = i;
				if (hit_at < 0) begin
					res.status = ST_MISS;
					n_misses++;
				end else begin
					res.index = hit_at[5:0];
					n_hits++;
				end
			end
			default: ;
		endcase
		if (res.status == ST_FULL) n_full++;
		if (res.status == ST_RANGE) n_range++;
		if (model_count > max_len) max_len = model_count;
		res.count = model_count[6:0];
		if (r.cmd == CMD_DUMP && n > 0) begin
			// One result per entry, in list order, the final one marked.
			for (i = 0; i < n; i++) begin
				res.index = i[5:0];
				res.value = model_entries[i];
				res.last  = (i == n - 1);
				list_results_due.push_back(res);
			end
		end else begin
			list_results_due.push_back(res);
		end
	endtask

	// Driver: presents queued requests, idling now and then.
	list_req_t on_bus;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_list_command(on_bus);
				accepted_reqs++;
			end
			if (!s_tvalid || s_tready) begin
				if (commands_to_send.size() > 0 && (steady || $urandom_range(0, 99) >= 9)) begin
					on_bus = commands_to_send.pop_front();
					s_tdata  <= {1'b0, on_bus.value, on_bus.pos};
					s_tuser  <= on_bus.cmd;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	// Monitor: checks each result against the oldest one owed, and drives
	// m_tready with random idling and one long hold-off.
	list_result_t due;
	int  hold_left = 0;
	bit  held_off  = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen_results++;
				if (list_results_due.size() == 0) begin
					$display("%0t: result with no request owing it, got %h", $time, m_tdata);
					fail_cnt++;
				end else begin
					due = list_results_due.pop_front();
					check_field("status", due.status, m_tdata[1:0]);
					check_field("index", due.index, m_tdata[7:2]);
					check_field("entry_value", due.value, m_tdata[39:8]);
					check_field("count", due.count, m_tdata[46:40]);
					check_field("empty_res", due.empty, m_tuser);
					check_field("last", due.last, m_tlast);
				end
			end
			if (!held_off && accepted_reqs >= 60) begin
				held_off  = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	// Watchdog: ends the run when nothing moves on either side for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		// Directed requests: empty list, edges of position and value,
		// duplicates for search, spare codes, clear.
		queue_request(CMD_DUMP, 0, 32'h0);
		queue_request(CMD_SEARCH, 0, 32'h0);
		queue_request(CMD_DELETE, 0, 32'h0);
		queue_request(CMD_INSERT, 1, 32'h1234_5678);
		queue_request(CMD_INSERT, 0, 32'h8000_0000);
		queue_request(CMD_APPEND, 0, 32'h7fff_ffff);
		queue_request(CMD_APPEND, 0, 32'hffff_ffff);
		queue_request(CMD_INSERT, 3, 32'h0000_0000);
		queue_request(CMD_INSERT, 64, 32'h5555_5555);
		queue_request(CMD_INSERT, 1, 32'h7fff_ffff);
		queue_request(CMD_SEARCH, 0, 32'h7fff_ffff);
		queue_request(CMD_SEARCH, 0, 32'h0000_0000);
		queue_request(CMD_SEARCH, 0, 32'h0000_3039);
		queue_request(CMD_DUMP, 0, 32'h0);
		queue_request(CMD_DELETE, 5, 32'h0);
		queue_request(CMD_DELETE, 4, 32'h0);
		queue_request(CMD_DELETE, 0, 32'h0);
		queue_request(CMD_SPARE6, 64, 32'hffff_ffff);
		queue_request(CMD_SPARE7, 0, 32'haaaa_aaaa);
		queue_request(CMD_DUMP, 0, 32'h0);
		queue_request(CMD_CLEAR, 0, 32'h0);
		queue_request(CMD_DUMP, 0, 32'h0);
		queue_request(CMD_APPEND, 64, 32'h0000_0001);

		// Random part, with up to two passes that fill the list completely;
		// a fill starts only while there is room for it in the request budget.
		begin : random_part
			int fills;
			fills = 0;
			while (reqs_queued < TOTAL_REQS) begin
				if (fills < 2 && reqs_queued < TOTAL_REQS - 80 &&
				    ($urandom_range(0, 29) == 0 || (fills == 0 && reqs_queued >= 200))) begin
					fill_list();
					fills++;
				end else begin
					queue_random_request();
				end
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_reqs < reqs_queued) @(posedge clk);
		while (list_results_due.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d dumps, longest list %0d) giving %0d results.",
		         accepted_reqs, n_dumps, max_len, seen_results);
		$display("Searches: %0d hits, %0d misses; rejected: %0d full, %0d out of range.",
		         n_hits, n_misses, n_full, n_range);
		if (fail_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== positional_list_insert_delete_search.f =====
sv/pli_pkg.sv
sv/pli_cell.sv
sv/positional_list_insert_delete_search.sv
sim/tb_positional_list_insert_delete_search.sv
